### rtl/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, operator codes and the precedence function for the
// infix-to-postfix converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itp_pkg;

    // Operator code width and codes
    localparam int OP_W = 4;

    localparam logic [OP_W-1:0] OP_ADD    = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB    = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL    = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV    = 4'd3;
    localparam logic [OP_W-1:0] OP_POW    = 4'd4;
    localparam logic [OP_W-1:0] OP_LPAREN = 4'd5;
    localparam logic [OP_W-1:0] OP_RPAREN = 4'd6;
    localparam logic [OP_W-1:0] OP_EQ     = 4'd7;
    localparam logic [OP_W-1:0] OP_LT     = 4'd8;
    localparam logic [OP_W-1:0] OP_GT     = 4'd9;
    localparam logic [OP_W-1:0] OP_COUNT  = 4'd10;

    // Input action codes
    typedef enum logic [1:0] {
        ACT_VALUE = 2'd0,
        ACT_OP    = 2'd1,
        ACT_END   = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // Output token kinds
    typedef enum logic [1:0] {
        KIND_VALUE = 2'd0,
        KIND_OP    = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    // Stack memory port control
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_stk_ctl;

    // Precedence of an operator code; parens and unknown codes rank lowest
    function automatic logic [2:0] op_prec(input logic [OP_W-1:0] op);
        logic [2:0] p;
        p = 3'd0;
        unique case (op)
            OP_ADD, OP_SUB:      p = 3'd2;
            OP_MUL, OP_DIV:      p = 3'd3;
            OP_POW:              p = 3'd4;
            OP_EQ, OP_LT, OP_GT: p = 3'd5;
            OP_LPAREN, OP_RPAREN: p = 3'd0;
            default:             p = 3'd0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

### rtl/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter - shunting-yard operator stack on a token stream
// Flow: an accepted item is captured and dispatched; a value goes straight to the
//   output register. An operator, right paren or end pops in S_LOOP (read) and
//   S_DECIDE (decide); an operator or left paren is then pushed in S_PUSH, and
//   S_FLUSH and, for an end, S_ENDMARK finish it. Emits wait for a free output.
// Throughput: one item at a time; the input stalls until the FSM is back in S_IDLE.
// Reset: synchronous; clears depth and error, stack memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input channel
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [1:0]  i_action,
    input  wire  [31:0] i_operand_value,
    input  wire  [3:0]  i_op_code,
    // output channel
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [1:0]  o_token_kind,
    output logic [31:0] o_out_value,
    output logic [3:0]  o_out_op,
    output logic        o_last,
    output logic        o_error
);
    import itp_pkg::*;

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int SX_SH  = (VALUE_WIDTH < 32) ? 32 - VALUE_WIDTH : 0;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DISPATCH = 7'b0000010,
        S_LOOP     = 7'b0000100,
        S_DECIDE   = 7'b0001000,
        S_PUSH     = 7'b0010000,
        S_FLUSH    = 7'b0100000,
        S_ENDMARK  = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_error, n_error;
    logic              r_pend_valid, n_pend_valid;
    logic [OP_W-1:0]   r_pend_op, n_pend_op;

    // captured transaction
    t_action           r_action;
    logic [OP_W-1:0]   r_op;
    logic [31:0]       r_val;

    // output register
    logic              r_out_valid, n_out_valid;
    t_kind             r_out_kind, n_out_kind;
    logic [31:0]       r_out_value, n_out_value;
    logic [OP_W-1:0]   r_out_op, n_out_op;
    logic              r_out_last, n_out_last;
    logic              r_out_error, n_out_error;

    // stack port
    t_stk_ctl          stk_ctl;
    logic [ADDR_W-1:0] stk_addr;
    logic [OP_W-1:0]   stk_rdata;

    logic              in_take;
    logic              out_free;
    logic              can_emit;
    logic              pop_ok;
    logic [2:0]        in_prec;
    logic [2:0]        top_prec;
    logic [CNT_W-1:0]  count_m1;
    logic [31:0]       val_sx;

    itp_op_stack #(
        .DEPTH  (STACK_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_stack (
        .i_clk   (i_clk),
        .i_ctl   (stk_ctl),
        .i_addr  (stk_addr),
        .i_wdata (r_op),
        .o_rdata (stk_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign can_emit   = !r_pend_valid || out_free;
    assign count_m1   = r_count - CNT_W'(1);
    assign stk_addr   = stk_ctl.wr_en ? r_count[ADDR_W-1:0] : count_m1[ADDR_W-1:0];

    // Precedence compare; power binds right so equal rank does not pop
    assign in_prec  = op_prec(r_op);
    assign top_prec = op_prec(stk_rdata);
    assign pop_ok   = (r_op == OP_POW) ? (in_prec < top_prec) : (in_prec <= top_prec);

    // Cut the value to its configured width and sign extend
    assign val_sx = 32'($signed(r_val << SX_SH) >>> SX_SH);

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_error      = r_error;
        n_pend_valid = r_pend_valid;
        n_pend_op    = r_pend_op;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_kind   = r_out_kind;
        n_out_value  = r_out_value;
        n_out_op     = r_out_op;
        n_out_last   = r_out_last;
        n_out_error  = r_out_error;
        stk_ctl      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_state = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                unique case (r_action)
                    ACT_VALUE: begin
                        if (out_free) begin
                            n_out_valid = 1'b1;
                            n_out_kind  = KIND_VALUE;
                            n_out_value = val_sx;
                            n_out_op    = '0;
                            n_out_last  = 1'b1;
                            n_out_error = 1'b0;
                            n_state     = S_IDLE;
                        end
                    end
                    ACT_OP: begin
                        if (r_op >= OP_COUNT) begin
                            n_error = 1'b1;
                            n_state = S_IDLE;
                        end else if (r_op == OP_LPAREN) begin
                            n_state = S_PUSH;
                        end else begin
                            n_state = S_LOOP;
                        end
                    end
                    ACT_END:  n_state = S_LOOP;
                    ACT_NONE: n_state = S_IDLE;
                    default:  n_state = S_IDLE;
                endcase
            end

            // Read the top entry, or end the pop run on an empty stack
            S_LOOP: begin
                if (r_count == '0) begin
                    if (r_action == ACT_END) begin
                        n_state = S_FLUSH;
                    end else if (r_op == OP_RPAREN) begin
                        n_error = 1'b1;
                        n_state = S_FLUSH;
                    end else begin
                        n_state = S_PUSH;
                    end
                end else begin
                    stk_ctl.rd_en = 1'b1;
                    n_state       = S_DECIDE;
                end
            end

            // Pop and emit the top, drop a left paren, or stop
            S_DECIDE: begin
                priority if (r_action == ACT_END && stk_rdata == OP_LPAREN) begin
                    n_error = 1'b1;
                    n_count = count_m1;
                    n_state = S_LOOP;
                end else if (r_action != ACT_END && r_op == OP_RPAREN
                             && stk_rdata == OP_LPAREN) begin
                    n_count = count_m1;
                    n_state = S_FLUSH;
                end else if (r_action != ACT_END && r_op != OP_RPAREN && !pop_ok) begin
                    n_state = S_PUSH;
                end else begin
                    // Hold the popped entry until the output register frees up
                    if (can_emit) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_kind  = KIND_OP;
                            n_out_value = '0;
                            n_out_op    = r_pend_op;
                            n_out_last  = 1'b0;
                            n_out_error = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_op    = stk_rdata;
                        n_count      = count_m1;
                        n_state      = S_LOOP;
                    end
                end
            end

            // Push the operator or left paren; drop it when full
            S_PUSH: begin
                if (r_count < CNT_W'(STACK_DEPTH)) begin
                    stk_ctl.wr_en = 1'b1;
                    n_count       = r_count + CNT_W'(1);
                end else begin
                    n_error = 1'b1;
                end
                n_state = S_FLUSH;
            end

            // Release the held operator, last unless an end marker follows
            S_FLUSH: begin
                if (!r_pend_valid || out_free) begin
                    if (r_pend_valid) begin
                        n_out_valid  = 1'b1;
                        n_out_kind   = KIND_OP;
                        n_out_value  = '0;
                        n_out_op     = r_pend_op;
                        n_out_last   = (r_action != ACT_END);
                        n_out_error  = 1'b0;
                        n_pend_valid = 1'b0;
                    end
                    n_state = (r_action == ACT_END) ? S_ENDMARK : S_IDLE;
                end
            end

            // Emit the end marker with the sticky error, then start afresh
            S_ENDMARK: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_END;
                    n_out_value = '0;
                    n_out_op    = '0;
                    n_out_last  = 1'b1;
                    n_out_error = r_error;
                    n_error     = 1'b0;
                    n_count     = '0;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_error      <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_error      <= n_error;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_action <= t_action'(i_action);
            r_op     <= i_op_code;
            r_val    <= i_operand_value;
        end
        r_pend_op   <= n_pend_op;
        r_out_kind  <= n_out_kind;
        r_out_value <= n_out_value;
        r_out_op    <= n_out_op;
        r_out_last  <= n_out_last;
        r_out_error <= n_out_error;
    end

    assign o_out_valid  = r_out_valid;
    assign o_token_kind = r_out_kind;
    assign o_out_value  = r_out_value;
    assign o_out_op     = r_out_op;
    assign o_last       = r_out_last;
    assign o_error      = r_out_error;

`ifndef SYNTHESIS
    // Stack depth never exceeds its capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("operator stack depth beyond capacity");

    // The single memory port is never asked to read and write at once
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(stk_ctl.wr_en && stk_ctl.rd_en))
        else $error("stack read and write in the same cycle");

    // No operator is held back while waiting for a new transaction
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_valid)
        else $error("held operator left behind in idle");

    // Issuing the end marker empties the stack and clears the error
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ENDMARK && out_free) |=> (r_count == '0 && !r_error))
        else $error("state not cleared after end marker");
`endif

endmodule

`default_nettype wire

### rtl/itp_op_stack.sv
// ----------------------------------------------------------------------------
// itp_op_stack
// Operator stack storage: single-port synchronous memory with a registered
// read, one access per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_op_stack #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  wire                      i_clk,
    input  wire itp_pkg::t_stk_ctl   i_ctl,
    input  wire [ADDR_W-1:0]         i_addr,
    input  wire [itp_pkg::OP_W-1:0]  i_wdata,
    output logic [itp_pkg::OP_W-1:0] o_rdata
);
    import itp_pkg::*;

    logic [OP_W-1:0] r_mem [DEPTH];
    logic [OP_W-1:0] r_rd_data;

    // Write the pushed entry
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // Read the top entry; hold the data until the next read
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rd_data;

endmodule

`default_nettype wire

### test/postfix_checker.sv
// ----------------------------------------------------------------------------
// postfix_checker
// Watches both channels of the infix-to-postfix converter, keeps its own
// operator stack to predict the postfix token stream, and compares each
// output transaction against the oldest predicted token.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module postfix_checker #(
    parameter int STACK_DEPTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input channel
    input  wire         i_in_valid,
    input  wire         i_in_stall,
    input  wire  [1:0]  i_action,
    input  wire  [31:0] i_operand_value,
    input  wire  [3:0]  i_op_code,
    // output channel
    input  wire         i_out_valid,
    input  wire         i_out_stall,
    input  wire  [1:0]  i_token_kind,
    input  wire  [31:0] i_out_value,
    input  wire  [3:0]  i_out_op,
    input  wire         i_last,
    input  wire         i_error,
    // status toward the testbench top
    output int          o_fail_count,
    output int          o_pending
);

    import itp_pkg::*;

    typedef struct {
        t_kind       kind;
        logic [31:0] value;
        logic [3:0]  op;
        logic        last;
        logic        error;
    } t_postfix_tok;

    // Binding strength per operator code; parens bind weakest
    localparam logic [2:0] RANK [0:9] = '{3'd2, 3'd2, 3'd3, 3'd3, 3'd4,
                                          3'd0, 3'd0, 3'd5, 3'd5, 3'd5};

    logic [3:0]   op_stack [STACK_DEPTH];
    int           stack_depth = 0;
    logic         expr_bad    = 1'b0;
    t_postfix_tok postfix_q [$];
    int           fail_count  = 0;

    function automatic t_postfix_tok make_tok(t_kind kind, logic [31:0] value,
                                              logic [3:0] op, logic error);
        t_postfix_tok t;
        t.kind  = kind;
        t.value = value;
        t.op    = op;
        t.last  = 1'b0;
        t.error = error;
        return t;
    endfunction

    // Push an operator, flag the expression when the stack is full
    task automatic push_op(input logic [3:0] op);
        if (stack_depth >= STACK_DEPTH) begin
            expr_bad = 1'b1;
        end else begin
            op_stack[stack_depth] = op;
            stack_depth++;
        end
    endtask

    // Predict the postfix tokens caused by one input transaction
    task automatic convert_item(input t_action act, input logic [31:0] val,
                                input logic [3:0] op);
        t_postfix_tok toks [$];
        logic [3:0]   top;
        logic         matched;
        case (act)
            ACT_VALUE: begin
                toks = {toks, make_tok(KIND_VALUE, val, '0, 1'b0)};
            end
            ACT_OP: begin
                if (op >= OP_COUNT) begin
                    expr_bad = 1'b1;
                end else if (op == OP_LPAREN) begin
                    push_op(op);
                end else if (op == OP_RPAREN) begin
                    // pop down to the matching left paren and drop it
                    matched = 1'b0;
                    while (stack_depth > 0 && !matched) begin
                        stack_depth--;
                        top = op_stack[stack_depth];
                        if (top == OP_LPAREN)
                            matched = 1'b1;
                        else
                            toks = {toks, make_tok(KIND_OP, '0, top, 1'b0)};
                    end
                    if (!matched)
                        expr_bad = 1'b1;
                end else begin
                    // pop operators of equal or higher rank; power only yields to stronger ones
                    while (stack_depth > 0) begin
                        top = op_stack[stack_depth - 1];
                        if ((op == OP_POW) ? (RANK[op] < RANK[top])
                                           : (RANK[op] <= RANK[top])) begin
                            stack_depth--;
                            toks = {toks, make_tok(KIND_OP, '0, top, 1'b0)};
                        end else begin
                            break;
                        end
                    end
                    push_op(op);
                end
            end
            ACT_END: begin
                // flush the stack; a leftover left paren marks a bad expression
                while (stack_depth > 0) begin
                    stack_depth--;
                    top = op_stack[stack_depth];
                    if (top == OP_LPAREN)
                        expr_bad = 1'b1;
                    else
                        toks = {toks, make_tok(KIND_OP, '0, top, 1'b0)};
                end
                toks = {toks, make_tok(KIND_END, '0, '0, expr_bad)};
                stack_depth = 0;
                expr_bad    = 1'b0;
            end
            default: begin
            end
        endcase
        if (toks.size() > 0)
            toks[toks.size() - 1].last = 1'b1;
        postfix_q = {postfix_q, toks};
    endtask

    function automatic int field_bad(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Compare one output transaction against the oldest predicted token
    task automatic check_token();
        t_postfix_tok want;
        if (postfix_q.size() == 0) begin
            $error("unexpected token: kind %0d value %0h op %0d",
                   i_token_kind, i_out_value, i_out_op);
            fail_count++;
        end else begin
            want = postfix_q.pop_front();
            fail_count += field_bad("token_kind", 32'(want.kind), 32'(i_token_kind));
            fail_count += field_bad("out_value", want.value, i_out_value);
            fail_count += field_bad("out_op", 32'(want.op), 32'(i_out_op));
            fail_count += field_bad("last", 32'(want.last), 32'(i_last));
            fail_count += field_bad("error", 32'(want.error), 32'(i_error));
        end
    endtask

    // Sample both channels at each rising edge once reset is released
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall)
                convert_item(t_action'(i_action), i_operand_value, i_op_code);
            if (i_out_valid && !i_out_stall)
                check_token();
        end
        o_fail_count <= fail_count;
        o_pending    <= postfix_q.size();
    end

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives token streams into the infix-to-postfix converter: a directed pass
// over precedence, associativity and the error cases, then random well-formed
// expressions, deep stack runs and noise, with random idle and stall bursts.
// The checker module predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    import itp_pkg::*;

    localparam int          RAND_ITEMS   = 410;
    localparam int          QUIET_ITEMS  = 70;
    localparam int          DRAIN_CYCLES = 100;
    localparam int          CYCLE_LIMIT  = 600000;
    localparam logic [3:0]  OP_BAD_HI    = 4'hF;
    localparam logic [3:0]  BIN_OPS [0:7] = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV,
                                              OP_POW, OP_EQ, OP_LT, OP_GT};

    logic        i_clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  in_action;
    logic [31:0] in_value;
    logic [3:0]  in_op;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  token_kind;
    logic [31:0] out_value;
    logic [3:0]  out_op;
    logic        out_last;
    logic        out_error;

    int fail_count;
    int pending;
    int items_sent  = 0;
    int cycle_count = 0;
    int idle_pct    = 15;
    int stall_pct   = 15;
    bit quiet       = 1'b0;
    bit noisy_expr  = 1'b0;

    infix_to_postfix_converter u_top (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_action        (in_action),
        .i_operand_value (in_value),
        .i_op_code       (in_op),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_token_kind    (token_kind),
        .o_out_value     (out_value),
        .o_out_op        (out_op),
        .o_last          (out_last),
        .o_error         (out_error)
    );

    postfix_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_action        (in_action),
        .i_operand_value (in_value),
        .i_op_code       (in_op),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_token_kind    (token_kind),
        .i_out_value     (out_value),
        .i_out_op        (out_op),
        .i_last          (out_last),
        .i_error         (out_error),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Hold off the output in random bursts
    initial begin
        int hold;
        hold = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0)
                hold--;
            else if (!quiet && $urandom_range(0, 99) < stall_pct)
                hold = $urandom_range(1, 5);
            out_stall <= (hold > 0);
        end
    end

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [3:0] rand_code();
        return 4'($urandom_range(0, 15));
    endfunction

    // Drive one transaction, optionally after an idle burst, and wait for it
    task automatic send_item(input t_action act, input logic [31:0] val,
                             input logic [3:0] op);
        int gap;
        if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        in_action <= act;
        in_value  <= val;
        in_op     <= op;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        if (act != ACT_NONE)
            items_sent++;
    endtask

    // Send a token, sometimes swapping in or adding a random one
    task automatic emit(input t_action act, input logic [3:0] op);
        if (noisy_expr && $urandom_range(0, 99) < 8) begin
            send_item(t_action'($urandom_range(0, 3)), rand_value(), rand_code());
            if ($urandom_range(0, 1))
                return;
        end
        send_item(act, rand_value(), op);
    endtask

    // Random well-formed expression with nested parens, then the end marker; noise may be mixed in
    task automatic send_expression();
        int operands;
        int depth;
        operands = $urandom_range(1, 8);
        depth    = 0;
        for (int n = 0; n < operands; n++) begin
            while (depth < 12 && $urandom_range(0, 3) == 0) begin
                emit(ACT_OP, OP_LPAREN);
                depth++;
            end
            emit(ACT_VALUE, rand_code());
            while (depth > 0 && $urandom_range(0, 2) == 0) begin
                emit(ACT_OP, OP_RPAREN);
                depth--;
            end
            if (n < operands - 1)
                emit(ACT_OP, BIN_OPS[$urandom_range(0, 7)]);
        end
        repeat (depth) emit(ACT_OP, OP_RPAREN);
        emit(ACT_END, rand_code());
    endtask

    // Drive the stack near, to or past its depth with power chains or left parens
    task automatic send_chain();
        int n;
        n = $urandom_range(28, 36);
        if ($urandom_range(0, 1)) begin
            send_item(ACT_VALUE, rand_value(), rand_code());
            repeat (n) begin
                send_item(ACT_OP, rand_value(), OP_POW);
                send_item(ACT_VALUE, rand_value(), rand_code());
            end
        end else begin
            repeat (n) send_item(ACT_OP, rand_value(), OP_LPAREN);
            send_item(ACT_VALUE, rand_value(), rand_code());
            repeat ($urandom_range(0, n)) send_item(ACT_OP, rand_value(), OP_RPAREN);
        end
        send_item(ACT_END, rand_value(), rand_code());
    endtask

    // Stimulus and verdict
    initial begin
        int start;
        int pick;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_action <= ACT_NONE;
        in_value  <= '0;
        in_op     <= OP_ADD;
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // precedence, power associativity and the value extremes
        send_item(ACT_OP,    rand_value(),  OP_LPAREN);
        send_item(ACT_VALUE, 32'h8000_0000, rand_code());
        send_item(ACT_OP,    rand_value(),  OP_ADD);
        send_item(ACT_VALUE, 32'h7FFF_FFFF, rand_code());
        send_item(ACT_OP,    rand_value(),  OP_RPAREN);
        send_item(ACT_OP,    rand_value(),  OP_MUL);
        send_item(ACT_VALUE, 32'h0,         rand_code());
        send_item(ACT_OP,    rand_value(),  OP_POW);
        send_item(ACT_VALUE, 32'hFFFF_FFFF, rand_code());
        send_item(ACT_OP,    rand_value(),  OP_POW);
        send_item(ACT_VALUE, rand_value(),  rand_code());
        send_item(ACT_OP,    rand_value(),  OP_SUB);
        send_item(ACT_VALUE, rand_value(),  rand_code());
        send_item(ACT_OP,    rand_value(),  OP_DIV);
        send_item(ACT_VALUE, rand_value(),  rand_code());
        send_item(ACT_OP,    rand_value(),  OP_EQ);
        send_item(ACT_VALUE, rand_value(),  rand_code());
        send_item(ACT_OP,    rand_value(),  OP_LT);
        send_item(ACT_VALUE, rand_value(),  rand_code());
        send_item(ACT_OP,    rand_value(),  OP_GT);
        send_item(ACT_VALUE, rand_value(),  rand_code());
        send_item(ACT_END,   rand_value(),  rand_code());

        // ignored action, unmatched right paren and bad operator codes
        send_item(ACT_NONE,  rand_value(),  rand_code());
        send_item(ACT_VALUE, rand_value(),  rand_code());
        send_item(ACT_OP,    rand_value(),  OP_RPAREN);
        send_item(ACT_OP,    rand_value(),  OP_COUNT);
        send_item(ACT_OP,    rand_value(),  OP_BAD_HI);
        send_item(ACT_END,   rand_value(),  rand_code());

        // left paren still open at the end marker
        send_item(ACT_OP,    rand_value(),  OP_LPAREN);
        send_item(ACT_VALUE, rand_value(),  rand_code());
        send_item(ACT_END,   rand_value(),  rand_code());

        // random phase: mostly well-formed, some deep runs and pure noise
        start = items_sent;
        while (items_sent - start < RAND_ITEMS) begin
            quiet = (items_sent - start) >= RAND_ITEMS - QUIET_ITEMS;
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 12;
                default: idle_pct = 35;
            endcase
            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 12;
                default: stall_pct = 35;
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 84) begin
                noisy_expr = ($urandom_range(0, 4) == 0);
                send_expression();
            end else if (pick < 90) begin
                send_chain();
            end else begin
                repeat ($urandom_range(1, 8))
                    send_item(t_action'($urandom_range(0, 3)), rand_value(), rand_code());
                if ($urandom_range(0, 1))
                    send_item(ACT_END, rand_value(), rand_code());
            end
        end
        in_valid <= 1'b0;

        // drain outstanding tokens, then allow for stragglers
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
